// ----- sv/sfpq_pkg.sv -----
// Package with the sizes, command codes and status codes of the six-slot priority queue.
`default_nettype none

package sfpq_pkg;

  localparam int CAPACITY   = 6;
  localparam int TAG_BITS   = 16;

  // Fixed widths of the request and result fields.
  localparam int CMD_W      = 3;
  localparam int TAG_W      = 16;
  localparam int HEIGHT_W   = 8;
  localparam int VALUE_W    = 32;
  localparam int SLOT_IDX_W = 3;
  localparam int STATUS_W   = 2;
  localparam int RATIO_W    = VALUE_W + 1;
  localparam int OCC_W      = 3;

  // Derived sizes of the store and its counters.
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PEEK_W     = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;
  localparam int DIV_STEPS  = VALUE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FIFO_DEQ = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PRIO_DEQ = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RATIO    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ----- sv/six_slot_fifo_priority_queue_top.sv -----
// Six-slot ordered store with FIFO and greatest-height removal, peek and a serial ratio divider.
//
//  Channel   | Handshake            | Signals
//  ----------+----------------------+---------------------------------------------------------
//  request   | start high, busy low | command, item_tag, item_height, item_value, slot_index
//  result    | done, one cycle      | status, out_tag, out_height, out_value, ratio, occupancy
//
// Enqueue, FIFO dequeue, peek, unused codes and requests on an empty store give their result
// in the cycle after acceptance and leave busy low. Priority dequeue scans the heights one slot
// per cycle through the shared compare unit. The ratio query runs the same scan and then a
// restoring divider of one quotient bit per cycle, or skips the divider for a zero divisor.
// Reset is synchronous and empties the store; the receiver cannot stall results.
`default_nettype none

module six_slot_fifo_priority_queue_top (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    start,
  output logic                                   busy,
  input  wire  [sfpq_pkg::CMD_W-1:0]             command,
  input  wire  [sfpq_pkg::TAG_W-1:0]             item_tag,
  input  wire  [sfpq_pkg::HEIGHT_W-1:0]          item_height,
  input  wire  signed [sfpq_pkg::VALUE_W-1:0]    item_value,
  input  wire  [sfpq_pkg::SLOT_IDX_W-1:0]        slot_index,
  output logic                                   done,
  output logic [sfpq_pkg::STATUS_W-1:0]          status,
  output logic [sfpq_pkg::TAG_W-1:0]             out_tag,
  output logic [sfpq_pkg::HEIGHT_W-1:0]          out_height,
  output logic signed [sfpq_pkg::VALUE_W-1:0]    out_value,
  output logic signed [sfpq_pkg::RATIO_W-1:0]    ratio,
  output logic [sfpq_pkg::OCC_W-1:0]             occupancy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_DIV,
    S_SIGN
  } state_t;

  state_t state;

  logic [sfpq_pkg::TAG_BITS-1:0] slot_tag    [sfpq_pkg::CAPACITY];
  logic [sfpq_pkg::HEIGHT_W-1:0] slot_height [sfpq_pkg::CAPACITY];
  logic [sfpq_pkg::VALUE_W-1:0]  slot_value  [sfpq_pkg::CAPACITY];
  logic [sfpq_pkg::CNT_W-1:0]    count;

  logic                          is_ratio;
  logic [sfpq_pkg::CNT_W-1:0]    scan_i;
  logic [sfpq_pkg::IDX_W-1:0]    best;
  logic [sfpq_pkg::HEIGHT_W-1:0] best_h;

  logic [sfpq_pkg::VALUE_W-1:0]  divisor;
  logic [sfpq_pkg::VALUE_W-1:0]  rem;
  logic [sfpq_pkg::VALUE_W-1:0]  quot;
  logic                          neg;
  logic [sfpq_pkg::DIV_CNT_W-1:0] step;

  logic [sfpq_pkg::IDX_W-1:0]    rd_sel;
  logic [sfpq_pkg::TAG_BITS-1:0] rd_tag;
  logic [sfpq_pkg::HEIGHT_W-1:0] rd_height;
  logic [sfpq_pkg::VALUE_W-1:0]  rd_value;

  logic [sfpq_pkg::VALUE_W:0]    rem_shift;
  logic [sfpq_pkg::VALUE_W:0]    rem_diff;
  logic [sfpq_pkg::VALUE_W-1:0]  rem_next;
  logic [sfpq_pkg::VALUE_W-1:0]  quot_next;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          peek_ok;
  logic [sfpq_pkg::VALUE_W-1:0]  num_mag;
  logic [sfpq_pkg::VALUE_W-1:0]  den_mag;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count >= sfpq_pkg::CNT_W'(sfpq_pkg::CAPACITY));
  assign empty  = (count == '0);
  assign peek_ok = (sfpq_pkg::PEEK_W'(slot_index) < sfpq_pkg::PEEK_W'(count));

  // The store has one muxed read port besides the fixed reads of slot 0; its address follows the step of the sequence.
  always_comb begin
    unique case (state)
      S_IDLE:  rd_sel = sfpq_pkg::IDX_W'(slot_index);
      S_SCAN:  rd_sel = scan_i[sfpq_pkg::IDX_W-1:0];
      default: rd_sel = best;
    endcase
  end

  assign rd_tag    = slot_tag[rd_sel];
  assign rd_height = slot_height[rd_sel];
  assign rd_value  = slot_value[rd_sel];

  // Magnitudes for the divider; the most negative value maps to 2^31 as an unsigned number.
  assign num_mag = slot_value[0][sfpq_pkg::VALUE_W-1] ? (-slot_value[0]) : slot_value[0];
  assign den_mag = rd_value[sfpq_pkg::VALUE_W-1] ? (-rd_value) : rd_value;

  // One restoring division step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_shift = {rem, quot[sfpq_pkg::VALUE_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    if (!rem_diff[sfpq_pkg::VALUE_W]) begin
      rem_next  = rem_diff[sfpq_pkg::VALUE_W-1:0];
      quot_next = {quot[sfpq_pkg::VALUE_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_shift[sfpq_pkg::VALUE_W-1:0];
      quot_next = {quot[sfpq_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      status    <= sfpq_pkg::ST_OK;
      out_tag   <= '0;
      out_height <= '0;
      out_value <= '0;
      ratio     <= '0;
      occupancy <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status     <= sfpq_pkg::ST_OK;
            out_tag    <= '0;
            out_height <= '0;
            out_value  <= '0;
            ratio      <= '0;
            occupancy  <= sfpq_pkg::OCC_W'(count);
            is_ratio   <= (command == sfpq_pkg::CMD_RATIO);
            best       <= '0;
            best_h     <= slot_height[0];
            scan_i     <= sfpq_pkg::CNT_W'(1);
            unique case (command)
              sfpq_pkg::CMD_ENQUEUE: begin
                done <= 1'b1;
                if (full) begin
                  status <= sfpq_pkg::ST_FULL;
                end else begin
                  slot_tag[count[sfpq_pkg::IDX_W-1:0]]    <= sfpq_pkg::TAG_BITS'(item_tag);
                  slot_height[count[sfpq_pkg::IDX_W-1:0]] <= item_height;
                  slot_value[count[sfpq_pkg::IDX_W-1:0]]  <= item_value;
                  count     <= count + 1'b1;
                  occupancy <= sfpq_pkg::OCC_W'(count + 1'b1);
                end
              end
              sfpq_pkg::CMD_FIFO_DEQ: begin
                done <= 1'b1;
                if (empty) begin
                  status <= sfpq_pkg::ST_EMPTY;
                end else begin
                  out_tag    <= sfpq_pkg::TAG_W'(slot_tag[0]);
                  out_height <= slot_height[0];
                  out_value  <= slot_value[0];
                  for (int i = 0; i < sfpq_pkg::CAPACITY - 1; i++) begin
                    slot_tag[i]    <= slot_tag[i+1];
                    slot_height[i] <= slot_height[i+1];
                    slot_value[i]  <= slot_value[i+1];
                  end
                  count     <= count - 1'b1;
                  occupancy <= sfpq_pkg::OCC_W'(count - 1'b1);
                end
              end
              sfpq_pkg::CMD_PRIO_DEQ, sfpq_pkg::CMD_RATIO: begin
                if (empty) begin
                  done   <= 1'b1;
                  status <= sfpq_pkg::ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              sfpq_pkg::CMD_PEEK: begin
                done <= 1'b1;
                if (peek_ok) begin
                  out_tag    <= sfpq_pkg::TAG_W'(rd_tag);
                  out_height <= rd_height;
                  out_value  <= rd_value;
                end else begin
                  status <= sfpq_pkg::ST_RANGE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Strictly greater wins, so the earliest of equal heights is kept.
          if (scan_i < count) begin
            if (rd_height > best_h) begin
              best   <= scan_i[sfpq_pkg::IDX_W-1:0];
              best_h <= rd_height;
            end
            scan_i <= scan_i + 1'b1;
          end else begin
            state <= S_PICK;
          end
        end

        S_PICK: begin
          if (!is_ratio) begin
            out_tag    <= sfpq_pkg::TAG_W'(rd_tag);
            out_height <= rd_height;
            out_value  <= rd_value;
            for (int i = 0; i < sfpq_pkg::CAPACITY - 1; i++) begin
              if (sfpq_pkg::IDX_W'(i) >= best) begin
                slot_tag[i]    <= slot_tag[i+1];
                slot_height[i] <= slot_height[i+1];
                slot_value[i]  <= slot_value[i+1];
              end
            end
            count     <= count - 1'b1;
            occupancy <= sfpq_pkg::OCC_W'(count - 1'b1);
            done      <= 1'b1;
            state     <= S_IDLE;
          end else if (rd_value == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            divisor <= den_mag;
            quot    <= num_mag;
            rem     <= '0;
            neg     <= slot_value[0][sfpq_pkg::VALUE_W-1] ^ rd_value[sfpq_pkg::VALUE_W-1];
            step    <= '0;
            state   <= S_DIV;
          end
        end

        S_DIV: begin
          rem  <= rem_next;
          quot <= quot_next;
          step <= step + 1'b1;
          if (step == sfpq_pkg::DIV_CNT_W'(sfpq_pkg::DIV_STEPS - 1)) begin
            state <= S_SIGN;
          end
        end

        S_SIGN: begin
          ratio <= neg ? -sfpq_pkg::RATIO_W'(quot) : sfpq_pkg::RATIO_W'(quot);
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sfpq_pkg::CNT_W'(sfpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result given while the sequencer is still working");

  a_enqueue_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && command == sfpq_pkg::CMD_ENQUEUE && !full) |=>
      (done && count == $past(count) + 1'b1 && status == sfpq_pkg::ST_OK))
    else $error("enqueue into a store with room did not add an entry");

  a_fifo_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && command == sfpq_pkg::CMD_FIFO_DEQ && !empty) |=>
      (done && count == $past(count) - 1'b1))
    else $error("FIFO dequeue did not remove an entry");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == sfpq_pkg::ST_FULL) |->
      (occupancy == sfpq_pkg::OCC_W'(sfpq_pkg::CAPACITY)))
    else $error("full status reported with room left");
`endif

endmodule

`default_nettype wire
